@@ rtl/qcfe_pkg.sv @@
// ----------------------------------------------------------------------------
// qcfe_pkg
// Shared types and constants of the QUIC CRYPTO frame extractor.
// ----------------------------------------------------------------------------
package qcfe_pkg;

  localparam int VW     = 62;
  localparam int POS_W  = 63;
  localparam int BYTE_W = 8;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [VW-1:0] FT_PADDING = VW'(0);
  localparam logic [VW-1:0] FT_PING    = VW'(1);
  localparam logic [VW-1:0] FT_CRYPTO  = VW'(6);

  localparam logic [5:0] VINT_LOW_MASK = 6'h3f;

  typedef struct packed {
    logic              has_data;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              has_status;
    logic              malformed;
  } evt_t;

endpackage

@@ rtl/quic_crypto_frame_extractor_top.sv @@
// ----------------------------------------------------------------------------
// quic_crypto_frame_extractor_top
// Extracts CRYPTO frame data with stream positions from a QUIC payload.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle on the input stream, as long as
// its 4-entry event queue has room. The output stage sends one result per
// cycle while the output is ready: a byte that yields both a data result and
// the closing status is sent as a data beat and then a status beat, and holds
// its queue entry until both are sent. A result passes through the event queue
// entry, written when its byte is taken, and then the output register.
module quic_crypto_frame_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] data_out, [70:8] stream_position,
                                      // [71] malformed
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // end_of_run
);
  import qcfe_pkg::*;

  evt_t              push_evt;
  evt_t              head;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;
  logic [BYTE_W-1:0] out_data;
  logic [POS_W-1:0]  out_pos;
  logic              out_malformed;

  qcfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .evt      (push_evt)
  );

  qcfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  qcfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_kind      (m_axis_tuser),
    .out_data      (out_data),
    .out_pos       (out_pos),
    .out_malformed (out_malformed),
    .out_end       (m_axis_tlast)
  );

  assign m_axis_tdata = {out_malformed, out_pos, out_data};

endmodule

@@ rtl/qcfe_front.sv @@
// ----------------------------------------------------------------------------
// qcfe_front
// Frame parser: decodes varints, tracks the CRYPTO fragment and produces one
// result event per payload byte that causes any result.
// ----------------------------------------------------------------------------
module qcfe_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qcfe_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  input  logic                      q_full,
  output logic                      push,
  output qcfe_pkg::evt_t            evt
);
  import qcfe_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_OFFSET,
    PH_LENGTH,
    PH_DATA
  } phase_t;

  phase_t          phase, phase_next;
  logic [VW-1:0]   vint_value, vint_value_next;
  logic [2:0]      vint_left, vint_left_next;
  logic [VW-1:0]   frag_offset, frag_offset_next;
  logic [VW-1:0]   frag_left, frag_left_next;
  logic [VW-1:0]   frag_index, frag_index_next;
  logic            stopped, stopped_next;
  logic            accept;
  logic [POS_W-1:0] cur_pos;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cur_pos  = {1'b0, frag_offset} + {1'b0, frag_index};

  always_comb begin
    phase_next       = phase;
    vint_value_next  = vint_value;
    vint_left_next   = vint_left;
    frag_offset_next = frag_offset;
    frag_left_next   = frag_left;
    frag_index_next  = frag_index;
    stopped_next     = stopped;
    evt              = '0;

    if (!stopped) begin
      if (phase == PH_DATA) begin
        evt.has_data    = 1'b1;
        evt.data        = in_byte;
        evt.pos         = cur_pos;
        frag_index_next = frag_index + VW'(1);
        frag_left_next  = frag_left - VW'(1);
        if (frag_left_next == '0) begin
          phase_next = PH_TYPE;
        end
      end else begin
        if (vint_left == 3'd0) begin
          vint_value_next = {{(VW-6){1'b0}}, in_byte[5:0] & VINT_LOW_MASK};
          unique case (in_byte[7:6])
            2'd0: vint_left_next = 3'd0;
            2'd1: vint_left_next = 3'd1;
            2'd2: vint_left_next = 3'd3;
            2'd3: vint_left_next = 3'd7;
          endcase
        end else begin
          vint_value_next = {vint_value[VW-BYTE_W-1:0], in_byte};
          vint_left_next  = vint_left - 3'd1;
        end
        if (vint_left_next == 3'd0) begin
          unique case (phase)
            PH_TYPE: begin
              if (vint_value_next == FT_CRYPTO) begin
                phase_next = PH_OFFSET;
              end else if (vint_value_next != FT_PADDING &&
                           vint_value_next != FT_PING) begin
                stopped_next = 1'b1;
              end
            end
            PH_OFFSET: begin
              frag_offset_next = vint_value_next;
              phase_next       = PH_LENGTH;
            end
            default: begin
              frag_left_next  = vint_value_next;
              frag_index_next = '0;
              phase_next      = (vint_value_next != '0) ? PH_DATA : PH_TYPE;
            end
          endcase
          vint_value_next = '0;
        end
      end
    end

    if (in_last) begin
      evt.has_status   = 1'b1;
      evt.malformed    = !stopped_next && (phase_next != PH_TYPE);
      phase_next       = PH_TYPE;
      vint_value_next  = '0;
      vint_left_next   = 3'd0;
      frag_offset_next = '0;
      frag_left_next   = '0;
      frag_index_next  = '0;
      stopped_next     = 1'b0;
    end

    push = accept && (evt.has_data || evt.has_status);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      vint_value  <= '0;
      vint_left   <= 3'd0;
      frag_offset <= '0;
      frag_left   <= '0;
      frag_index  <= '0;
      stopped     <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      vint_value  <= vint_value_next;
      vint_left   <= vint_left_next;
      frag_offset <= frag_offset_next;
      frag_left   <= frag_left_next;
      frag_index  <= frag_index_next;
      stopped     <= stopped_next;
    end
  end

endmodule

@@ rtl/qcfe_queue.sv @@
// ----------------------------------------------------------------------------
// qcfe_queue
// Short event queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module qcfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qcfe_pkg::evt_t push_evt,
  input  logic           pop,
  output qcfe_pkg::evt_t head,
  output logic           empty,
  output logic           full
);
  import qcfe_pkg::*;

  evt_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QAW+1)'(QDEPTH));
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/qcfe_back.sv @@
// ----------------------------------------------------------------------------
// qcfe_back
// Output stage: turns each queued event into its data and status beats.
// ----------------------------------------------------------------------------
module qcfe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  qcfe_pkg::evt_t              head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [qcfe_pkg::BYTE_W-1:0] out_data,
  output logic [qcfe_pkg::POS_W-1:0]  out_pos,
  output logic                        out_malformed,
  output logic                        out_end
);
  import qcfe_pkg::*;

  logic data_done;
  logic load;
  logic send_data;

  assign load      = !empty && (!out_valid || out_ready);
  assign send_data = head.has_data && !data_done;
  assign pop       = load && (!send_data || !head.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      data_done <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      data_done <= send_data && head.has_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_data) begin
        out_kind      <= 1'b0;
        out_data      <= head.data;
        out_pos       <= head.pos;
        out_malformed <= 1'b0;
        out_end       <= 1'b0;
      end else begin
        out_kind      <= 1'b1;
        out_data      <= '0;
        out_pos       <= '0;
        out_malformed <= head.malformed;
        out_end       <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/qcfe_checker.sv @@
// ----------------------------------------------------------------------------
// qcfe_checker
// Port-level checks of the extractor's result stream.
// ----------------------------------------------------------------------------
module qcfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_data_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast && !m_axis_tdata[71])
    else $error("data beat carries status bits");

  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[70:0] == '0))
    else $error("status beat carries data");

endmodule

bind quic_crypto_frame_extractor_top qcfe_checker u_qcfe_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
